[src/cpic_pkg.sv]
// ----------------------------------------------------------------------------
// cpic_pkg
// Shared types and constants of the counting priority interrupt controller.
// ----------------------------------------------------------------------------
package cpic_pkg;

    // number of interrupt sources, one cell each
    localparam int NUM_SOURCES = 8;
    // width of each pending-request counter
    localparam int COUNT_WIDTH = 8;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int SRC_W       = 3;
    localparam int VEC_W       = 8;
    localparam int SCOUNT_W    = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;

    // transaction operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RAISE   = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_SERVICE = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_COUNT = 1'b0,
        CFG_VECTOR_TABLE = 1'b1
    } cfg_idx_t;

    // per-cell control from the top level
    typedef struct packed {
        logic raise;    // accepted raise on this cell
        logic clear;    // accepted clear on this cell
        logic service;  // accepted service that the cpu takes
        logic active;   // cell is below the source count
        logic drop;     // source count write deactivates this cell
    } cell_ctrl_t;

endpackage

[src/counting_priority_interrupt_controller.sv]
// the result of an accepted input transaction is registered and shows in the cycle after it
// throughput: one transaction per cycle while the result side keeps up
// the priority claim ripples combinationally through the chain of eight source cells
// reset: all pending counters, the source count and the vector table clear at once
// ----------------------------------------------------------------------------
// counting_priority_interrupt_controller
// Fixed-priority interrupt controller with a pending counter per source.
// Raise, clear and service transactions act on a chain of source cells; every
// transaction returns one result held in an output register.
// ----------------------------------------------------------------------------
module counting_priority_interrupt_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write_en,
    input  logic [cpic_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpic_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cpic_pkg::OP_W-1:0]           operation,
    input  logic [cpic_pkg::SRC_W-1:0]          source,
    input  logic                                cpu_accepts,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                served,
    output logic [cpic_pkg::SRC_W-1:0]          served_source,
    output logic [cpic_pkg::VEC_W-1:0]          vector
);

    logic [cpic_pkg::SCOUNT_W-1:0]                          source_count_reg;
    logic [cpic_pkg::NUM_SOURCES-1:0][cpic_pkg::VEC_W-1:0]  vector_table_reg;

    logic                                   out_valid_reg;
    logic                                   served_reg;
    logic [cpic_pkg::SRC_W-1:0]             served_source_reg;
    logic [cpic_pkg::VEC_W-1:0]             vector_reg;

    logic                                   in_fire;
    logic                                   do_raise;
    logic                                   do_clear;
    logic                                   do_service;
    logic                                   count_write;

    cpic_pkg::cell_ctrl_t [cpic_pkg::NUM_SOURCES-1:0] cell_ctrl;
    logic [cpic_pkg::NUM_SOURCES:0]         claim;
    logic [cpic_pkg::NUM_SOURCES-1:0]       grant;

    logic                                   served_next;
    logic [cpic_pkg::SRC_W-1:0]             served_source_next;
    logic [cpic_pkg::VEC_W-1:0]             vector_next;

    // handshake: a new transaction enters when the result register frees up
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign served        = served_reg;
    assign served_source = served_source_reg;
    assign vector        = vector_reg;

    // operation decode
    always_comb
    begin
        do_raise   = 1'b0;
        do_clear   = 1'b0;
        do_service = 1'b0;
        unique case (operation)
            cpic_pkg::OP_RAISE:   do_raise   = in_fire;
            cpic_pkg::OP_CLEAR:   do_clear   = in_fire;
            cpic_pkg::OP_SERVICE: do_service = in_fire && cpu_accepts;
            default:
            begin
                do_raise   = 1'b0;
                do_clear   = 1'b0;
                do_service = 1'b0;
            end
        endcase
    end

    assign count_write = cfg_write_en && (cfg_index == cpic_pkg::CFG_SOURCE_COUNT);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= '0;
            vector_table_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                cpic_pkg::CFG_SOURCE_COUNT:
                    source_count_reg <= cfg_data[cpic_pkg::SCOUNT_W-1:0];
                cpic_pkg::CFG_VECTOR_TABLE:
                    vector_table_reg <= cfg_data;
                default:
                    source_count_reg <= source_count_reg;
            endcase
        end
    end

    // per-cell control, active mask from the stored and the new source count
    always_comb
    begin
        for (int i = 0; i < cpic_pkg::NUM_SOURCES; i++)
        begin
            cell_ctrl[i].raise   = do_raise && (source == cpic_pkg::SRC_W'(i));
            cell_ctrl[i].clear   = do_clear && (source == cpic_pkg::SRC_W'(i));
            cell_ctrl[i].service = do_service;
            cell_ctrl[i].active  = source_count_reg > cpic_pkg::SCOUNT_W'(i);
            cell_ctrl[i].drop    = count_write &&
                !(cfg_data[cpic_pkg::SCOUNT_W-1:0] > cpic_pkg::SCOUNT_W'(i));
        end
    end

    // chain of source cells, lowest index has highest priority
    assign claim[0] = 1'b0;

    for (genvar g = 0; g < cpic_pkg::NUM_SOURCES; g++)
    begin : g_cell
        cpic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[g]),
            .claim_in  (claim[g]),
            .claim_out (claim[g+1]),
            .grant     (grant[g])
        );
    end

    // encode the granted source and pick its vector byte
    always_comb
    begin
        served_next        = |grant;
        served_source_next = '0;
        vector_next        = '0;
        for (int i = 0; i < cpic_pkg::NUM_SOURCES; i++)
        begin
            if (grant[i])
            begin
                served_source_next = served_source_next | cpic_pkg::SRC_W'(i);
                vector_next        = vector_next | vector_table_reg[i];
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            served_reg        <= served_next;
            served_source_reg <= served_source_next;
            vector_reg        <= vector_next;
        end
    end

    // at most one cell wins a service
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant))
        else $error("more than one source granted");

    // a grant only comes from an accepted service the cpu takes
    a_grant_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (|grant) |-> (in_fire && cpu_accepts &&
                      (operation == cpic_pkg::OP_SERVICE)))
        else $error("grant without an accepted service");

    // a refused service yields no interrupt
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cpu_accepts) |=> (out_valid && !served))
        else $error("interrupt served while cpu refuses");

    // a result without an interrupt carries zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !served) |-> (served_source == '0 && vector == '0))
        else $error("nonzero fields on an empty result");

endmodule

[src/cpic_cell.sv]
// ----------------------------------------------------------------------------
// cpic_cell
// One interrupt source: pending counter with saturating raise, clear and
// service decrement, plus its link in the fixed-priority claim chain.
// ----------------------------------------------------------------------------
module cpic_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpic_pkg::cell_ctrl_t                ctrl,
    input  logic                                claim_in,
    output logic                                claim_out,
    output logic                                grant
);

    logic [cpic_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [cpic_pkg::COUNT_WIDTH-1:0] count_next;
    logic                             pending;

    // this cell has requests that count for priority
    assign pending   = ctrl.active && (count_reg != '0);
    assign claim_out = claim_in || pending;
    assign grant     = ctrl.service && pending && !claim_in;

    // counter update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.drop)
        begin
            count_next = '0;
        end
        else if (ctrl.raise && ctrl.active && !(&count_reg))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.clear && ctrl.active)
        begin
            count_next = '0;
        end
        else if (grant)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule
